// ----- rtl/abdr_pkg.sv -----
`timescale 1ns / 1ps
package abdr_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;
  localparam int SampleWidth   = 10;
  localparam int TimeWidth     = 32;
  localparam int CountWidth    = 9;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexWidth-1:0] REG_ANALOG_THRESHOLD   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_PULLUP_MODE        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_COUNT_THRESHOLD    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SAMPLE_DELAY       = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_HELD_MS            = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_REPEAT_INITIAL_MS  = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_REPEAT_INTERVAL_MS = 3'd6;

  localparam logic [1:0] REPEAT_NONE  = 2'd0;
  localparam logic [1:0] REPEAT_FIRST = 2'd1;
  localparam logic [1:0] REPEAT_LATER = 2'd2;

  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef struct packed {
    logic [9:0]  analog_threshold;
    logic        pullup_mode;
    logic [7:0]  count_threshold;
    logic [7:0]  sample_delay;
    logic [15:0] held_ms;
    logic [15:0] repeat_initial_ms;
    logic [15:0] repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic                 pressed_state;
    logic                 pushed_flag;
    logic [TimeWidth-1:0] tap_duration;
    logic                 held_flag;
    logic                 repeat_fire;
  } res_t;

endpackage

// ----- rtl/abdr_cfg.sv -----
`timescale 1ns / 1ps
module abdr_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [abdr_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [abdr_pkg::CfgDataWidth-1:0]    cfg_data,
  output abdr_pkg::cfg_t                       cfg
);
  import abdr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.analog_threshold   <= 10'd512;
      cfg.pullup_mode        <= 1'b1;
      cfg.count_threshold    <= 8'd5;
      cfg.sample_delay       <= 8'd5;
      cfg.held_ms            <= 16'd1000;
      cfg.repeat_initial_ms  <= 16'd500;
      cfg.repeat_interval_ms <= 16'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ANALOG_THRESHOLD:   cfg.analog_threshold   <= cfg_data[9:0];
        REG_PULLUP_MODE:        cfg.pullup_mode        <= cfg_data[0];
        REG_COUNT_THRESHOLD:    cfg.count_threshold    <= cfg_data[7:0];
        REG_SAMPLE_DELAY:       cfg.sample_delay       <= cfg_data[7:0];
        REG_HELD_MS:            cfg.held_ms            <= cfg_data;
        REG_REPEAT_INITIAL_MS:  cfg.repeat_initial_ms  <= cfg_data;
        REG_REPEAT_INTERVAL_MS: cfg.repeat_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/abdr_core.sv -----
`timescale 1ns / 1ps
module abdr_core (
  input  logic                              clk,
  input  logic                              rst,
  input  abdr_pkg::cfg_t                    cfg,
  input  logic                              step,
  input  logic [abdr_pkg::SampleWidth-1:0]  analog_sample,
  input  logic                              read_pushed,
  input  logic                              read_tapped,
  input  logic                              poll_repeat,
  output abdr_pkg::res_t                    res
);
  import abdr_pkg::*;

  logic [TimeWidth-1:0]  now_ms;
  logic [TimeWidth-1:0]  last_sample_time;
  logic [CountWidth-1:0] disagree_count;
  logic                  debounced_state;
  logic                  pushed_latch;
  logic [TimeWidth-1:0]  press_duration;
  logic [TimeWidth-1:0]  last_change_time;
  logic [TimeWidth-1:0]  last_repeat_time;
  logic [1:0]            repeat_count;

  logic [CountWidth-1:0] disagree_count_next;
  logic [TimeWidth-1:0]  press_duration_next;
  logic [1:0]            repeat_count_next;

  logic                  raw;
  logic                  run;
  logic                  disagree;
  logic [CountWidth-1:0] count_inc;
  logic                  toggle;
  logic                  press;
  logic                  release_evt;
  logic                  state_new;
  logic                  pushed_new;
  logic [TimeWidth-1:0]  since_change;
  logic [TimeWidth-1:0]  since_repeat;
  logic [15:0]           gap;
  logic                  fire;

  always_comb begin
    if (cfg.pullup_mode) raw = (analog_sample <= cfg.analog_threshold);
    else                 raw = (analog_sample >  cfg.analog_threshold);

    run       = ((now_ms - last_sample_time) > {24'd0, cfg.sample_delay});
    disagree  = (raw != debounced_state);
    count_inc = (disagree_count < CountMax) ? disagree_count + 1'b1 : disagree_count;
    toggle    = run && disagree && (count_inc > {1'b0, cfg.count_threshold});
    press       = toggle && !debounced_state;
    release_evt = toggle && debounced_state;
    state_new   = debounced_state ^ toggle;
    pushed_new  = pushed_latch | press;

    since_change = now_ms - last_change_time;
    since_repeat = now_ms - last_repeat_time;

    if (release_evt) press_duration_next = since_change;
    else             press_duration_next = press_duration;

    if (!run)          disagree_count_next = disagree_count;
    else if (!disagree || toggle) disagree_count_next = '0;
    else               disagree_count_next = count_inc;

    gap = (repeat_count == REPEAT_FIRST) ? cfg.repeat_initial_ms : cfg.repeat_interval_ms;
    // A fresh press restarts the repeat sequence, so it always fires on a poll.
    fire = poll_repeat && state_new &&
           (press || repeat_count == REPEAT_NONE || since_repeat > {16'd0, gap});

    if (press)
      repeat_count_next = fire ? REPEAT_FIRST : REPEAT_NONE;
    else if (fire && repeat_count != REPEAT_LATER)
      repeat_count_next = repeat_count + 1'b1;
    else
      repeat_count_next = repeat_count;

    res.pressed_state = state_new;
    res.pushed_flag   = pushed_new;
    res.tap_duration  = press_duration_next;
    res.held_flag     = state_new && !toggle && (since_change > {16'd0, cfg.held_ms});
    res.repeat_fire   = fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms           <= '0;
      last_sample_time <= '0;
      disagree_count   <= '0;
      debounced_state  <= 1'b0;
      pushed_latch     <= 1'b0;
      press_duration   <= '0;
      last_change_time <= '0;
      last_repeat_time <= '0;
      repeat_count     <= REPEAT_NONE;
    end else if (step) begin
      now_ms          <= now_ms + 1'b1;
      if (run) last_sample_time <= now_ms;
      disagree_count  <= disagree_count_next;
      debounced_state <= state_new;
      pushed_latch    <= read_pushed ? 1'b0 : pushed_new;
      press_duration  <= read_tapped ? '0 : press_duration_next;
      if (toggle) last_change_time <= now_ms;
      if (press || fire) last_repeat_time <= now_ms;
      repeat_count    <= repeat_count_next;
    end
  end

endmodule

// ----- rtl/abdr_outbuf.sv -----
`timescale 1ns / 1ps
module abdr_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  abdr_pkg::res_t wr_data,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_stall,
  output abdr_pkg::res_t rd_data
);
  import abdr_pkg::*;

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_en    = rd_valid && !rd_stall;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (rd_en) rd_ptr <= !rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/analog_button_debounce_repeat.sv -----
`timescale 1ns / 1ps
// A tick item's result is written into the result queue at the accepting edge and is valid in the cycle after it.
// Throughput: one item per cycle while the result queue is not full; all state updates are done in the accepting cycle.
// A two-entry result queue keeps input accepted while one result waits to be taken.
// Reset clears all timing and button state and loads the register defaults.
module analog_button_debounce_repeat (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  analog_sample,
  input  logic        read_pushed,
  input  logic        read_tapped,
  input  logic        poll_repeat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pressed_state,
  output logic        pushed_flag,
  output logic [31:0] tap_duration,
  output logic        held_flag,
  output logic        repeat_fire
);
  import abdr_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic step;
  logic full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign step      = in_valid && !full;

  abdr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abdr_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (step),
    .analog_sample (analog_sample),
    .read_pushed   (read_pushed),
    .read_tapped   (read_tapped),
    .poll_repeat   (poll_repeat),
    .res           (res)
  );

  abdr_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (step),
    .wr_data  (res),
    .full     (full),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (out_res)
  );

  assign pressed_state = out_res.pressed_state;
  assign pushed_flag   = out_res.pushed_flag;
  assign tap_duration  = out_res.tap_duration;
  assign held_flag     = out_res.held_flag;
  assign repeat_fire   = out_res.repeat_fire;

endmodule

// ----- tb/tb_analog_button_debounce_repeat.sv -----
`timescale 1ns / 1ps
module tb_analog_button_debounce_repeat;
  import abdr_pkg::*;

  localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 3'd7;
  localparam int IdleLimit = 500;

  // Tracks the button from the accepted tick items and holds the reports
  // that the block still owes.
  class button_tracker;
    cfg_t        cfg;
    res_t        pending_reports[$];
    logic [31:0] tick_ms;
    logic [31:0] last_sample_ms;
    logic [31:0] change_ms;
    logic [31:0] repeat_ms;
    logic [31:0] press_len;
    logic [8:0]  disagree;
    logic        pressed;
    logic        pushed;
    logic [1:0]  repeat_stage;
    int          failures;
    int          checked;
    int          presses;
    int          releases;
    int          held_seen;
    int          fires_seen;

    function new();
      cfg.analog_threshold   = 10'd512;
      cfg.pullup_mode        = 1'b1;
      cfg.count_threshold    = 8'd5;
      cfg.sample_delay       = 8'd5;
      cfg.held_ms            = 16'd1000;
      cfg.repeat_initial_ms  = 16'd500;
      cfg.repeat_interval_ms = 16'd100;
      tick_ms        = '0;
      last_sample_ms = '0;
      change_ms      = '0;
      repeat_ms      = '0;
      press_len      = '0;
      disagree       = '0;
      pressed        = 1'b0;
      pushed         = 1'b0;
      repeat_stage   = REPEAT_NONE;
      failures       = 0;
      checked        = 0;
      presses        = 0;
      releases       = 0;
      held_seen      = 0;
      fires_seen     = 0;
    endfunction

    function void set_register(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_ANALOG_THRESHOLD:   cfg.analog_threshold   = data[9:0];
        REG_PULLUP_MODE:        cfg.pullup_mode        = data[0];
        REG_COUNT_THRESHOLD:    cfg.count_threshold    = data[7:0];
        REG_SAMPLE_DELAY:       cfg.sample_delay       = data[7:0];
        REG_HELD_MS:            cfg.held_ms            = data;
        REG_REPEAT_INITIAL_MS:  cfg.repeat_initial_ms  = data;
        REG_REPEAT_INTERVAL_MS: cfg.repeat_interval_ms = data;
        default: ;
      endcase
    endfunction

    function void take_tick(logic [9:0] sample, logic clr_pushed, logic clr_tapped,
                            logic poll);
      logic        raw;
      logic [31:0] elapsed;
      logic [15:0] gap;
      res_t        r;
      if (cfg.pullup_mode) raw = (sample <= cfg.analog_threshold);
      else raw = (sample > cfg.analog_threshold);

      elapsed = tick_ms - last_sample_ms;
      if (elapsed > cfg.sample_delay) begin
        last_sample_ms = tick_ms;
        if (raw != pressed) begin
          if (disagree != CountMax) disagree = disagree + 9'd1;
          if (disagree > cfg.count_threshold) begin
            if (!pressed) begin
              pushed       = 1'b1;
              repeat_stage = REPEAT_NONE;
              repeat_ms    = tick_ms;
              presses++;
            end else begin
              press_len = tick_ms - change_ms;
              releases++;
            end
            pressed   = !pressed;
            change_ms = tick_ms;
            disagree  = '0;
          end
        end else begin
          disagree = '0;
        end
      end

      elapsed         = tick_ms - change_ms;
      r.pressed_state = pressed;
      r.pushed_flag   = pushed;
      r.tap_duration  = press_len;
      r.held_flag     = pressed && (elapsed > cfg.held_ms);
      r.repeat_fire   = 1'b0;

      if (poll && pressed) begin
        gap     = (repeat_stage == REPEAT_FIRST) ? cfg.repeat_initial_ms
                                                 : cfg.repeat_interval_ms;
        elapsed = tick_ms - repeat_ms;
        if (repeat_stage == REPEAT_NONE || elapsed > gap) begin
          r.repeat_fire = 1'b1;
          repeat_ms     = tick_ms;
          if (repeat_stage != REPEAT_LATER) repeat_stage = repeat_stage + 2'd1;
        end
      end

      if (r.held_flag) held_seen++;
      if (r.repeat_fire) fires_seen++;
      pending_reports.push_back(r);

      if (clr_pushed) pushed = 1'b0;
      if (clr_tapped) press_len = '0;
      tick_ms = tick_ms + 32'd1;
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (pending_reports.size() == 0) begin
        $error("result item arrived with no tick waiting for it");
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got.pressed_state !== want.pressed_state) begin
        $error("pressed_state: expected %0d, got %0d", want.pressed_state, got.pressed_state);
        failures++;
      end
      if (got.pushed_flag !== want.pushed_flag) begin
        $error("pushed_flag: expected %0d, got %0d", want.pushed_flag, got.pushed_flag);
        failures++;
      end
      if (got.tap_duration !== want.tap_duration) begin
        $error("tap_duration: expected %0d, got %0d", want.tap_duration, got.tap_duration);
        failures++;
      end
      if (got.held_flag !== want.held_flag) begin
        $error("held_flag: expected %0d, got %0d", want.held_flag, got.held_flag);
        failures++;
      end
      if (got.repeat_fire !== want.repeat_fire) begin
        $error("repeat_fire: expected %0d, got %0d", want.repeat_fire, got.repeat_fire);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [9:0]  analog_sample = '0;
  logic        read_pushed = 1'b0;
  logic        read_tapped = 1'b0;
  logic        poll_repeat = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        pressed_state;
  logic        pushed_flag;
  logic [31:0] tap_duration;
  logic        held_flag;
  logic        repeat_fire;

  button_tracker tracker;
  int idle_cycles = 0;
  int stall_cycle = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int settings_used = 0;

  analog_button_debounce_repeat uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .analog_sample (analog_sample),
    .read_pushed   (read_pushed),
    .read_tapped   (read_tapped),
    .poll_repeat   (poll_repeat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pressed_state (pressed_state),
    .pushed_flag   (pushed_flag),
    .tap_duration  (tap_duration),
    .held_flag     (held_flag),
    .repeat_fire   (repeat_fire)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver steps through four stall behaviors in turn: none, light,
  // periodic and heavy.
  always @(negedge clk) begin
    stall_cycle++;
    case ((stall_cycle / 150) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_cycle % 7) < 3);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    res_t got;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        got.pressed_state = pressed_state;
        got.pushed_flag   = pushed_flag;
        got.tap_duration  = tap_duration;
        got.held_flag     = held_flag;
        got.repeat_fire   = repeat_fire;
        tracker.check_report(got);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        tracker.take_tick(analog_sample, read_pushed, read_tapped, poll_repeat);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles", IdleLimit);
        $display("analog_button_debounce_repeat test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Narrow registers get random upper bits, which the block must drop.
  task automatic apply_settings(input logic [9:0] thr, input logic pu,
                                input logic [7:0] cnt, input logic [7:0] dly,
                                input logic [15:0] held, input logic [15:0] first_gap,
                                input logic [15:0] later_gap);
    logic [15:0] pad;
    pad = 16'($urandom);
    write_reg(REG_ANALOG_THRESHOLD, {pad[15:10], thr});
    write_reg(REG_PULLUP_MODE, {pad[14:0], pu});
    write_reg(REG_COUNT_THRESHOLD, {pad[7:0], cnt});
    write_reg(REG_SAMPLE_DELAY, {pad[15:8], dly});
    write_reg(REG_HELD_MS, held);
    write_reg(REG_REPEAT_INITIAL_MS, first_gap);
    write_reg(REG_REPEAT_INTERVAL_MS, later_gap);
    settings_used++;
    gaps_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic random_settings();
    logic [9:0]  thr;
    logic [7:0]  cnt;
    logic [7:0]  dly;
    logic [15:0] held;
    logic [15:0] first_gap;
    logic [15:0] later_gap;
    case ($urandom_range(0, 5))
      0: thr = '0;
      1: thr = '1;
      default: thr = 10'($urandom_range(1, 1022));
    endcase
    cnt       = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3));
    dly       = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3));
    held      = 16'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 40));
    first_gap = 16'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 30));
    later_gap = 16'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 10));
    apply_settings(thr, 1'($urandom_range(0, 1)), cnt, dly, held, first_gap, later_gap);
  endtask

  task automatic send_tick(input logic [9:0] sample, input logic rp, input logic rt,
                           input logic poll);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    analog_sample <= sample;
    read_pushed   <= rp;
    read_tapped   <= rt;
    poll_repeat   <= poll;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender off until every owed report has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // A sample that reads as the wanted level under the current threshold and
  // pull-up setting, or any sample when none can, with a bias toward the edges of that range.
  function automatic logic [9:0] level_sample(bit want_pressed);
    logic [9:0] thr;
    bit         upper;
    int         lo;
    int         hi;
    thr   = tracker.cfg.analog_threshold;
    upper = (want_pressed != tracker.cfg.pullup_mode);
    if (upper) begin
      if (thr == 10'h3FF) return 10'($urandom_range(0, 1023));
      lo = thr + 1;
      hi = 1023;
    end else begin
      lo = 0;
      hi = thr;
    end
    case ($urandom_range(0, 7))
      0: return 10'(lo);
      1: return 10'(hi);
      default: return 10'($urandom_range(hi, lo));
    endcase
  endfunction

  // Mostly steady press and release stretches with a few bounces, mixed with
  // bursts of pure noise.
  task automatic run_buttons(input int n_items);
    int done;
    int span;
    int span_max;
    bit level;
    bit noise;
    logic [9:0] sample;
    done  = 0;
    level = $urandom_range(0, 1);
    while (done < n_items) begin
      noise = ($urandom_range(0, 4) == 0);
      if (noise) begin
        span = $urandom_range(1, 8);
      end else begin
        level    = !level;
        span_max = (int'(tracker.cfg.count_threshold) + 1) *
                   (int'(tracker.cfg.sample_delay) + 1) + int'(tracker.cfg.held_ms) + 20;
        if (span_max > 90) span_max = 90;
        span = $urandom_range(span_max / 3 + 1, span_max);
      end
      for (int i = 0; i < span && done < n_items; i++) begin
        if (noise) sample = 10'($urandom_range(0, 1023));
        else if ($urandom_range(0, 11) == 0) sample = level_sample(!level);
        else sample = level_sample(level);
        send_tick(sample, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 2) != 0);
        done++;
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Register defaults straight out of reset.
    send_tick(10'd0, 1'b0, 1'b0, 1'b1);
    send_tick(10'd1023, 1'b1, 1'b1, 1'b1);
    send_tick(10'd512, 1'b0, 1'b0, 1'b0);
    send_tick(10'd513, 1'b1, 1'b0, 1'b1);
    send_tick(10'd0, 1'b0, 1'b1, 1'b1);
    send_tick(10'd0, 1'b1, 1'b1, 1'b1);
    send_tick(10'd0, 1'b0, 1'b0, 1'b1);
    drain();

    // A write to the unused index must change nothing.
    write_reg(REG_UNUSED, 16'hFFFF);
    apply_settings(10'd512, 1'b1, 8'd0, 8'd0, 16'd2, 16'd1, 16'd0);
    // Press on the threshold itself, then the repeat ladder: immediate fire,
    // initial gap, interval gap, then held and the clear-on-read flags.
    send_tick(10'd512, 1'b0, 1'b0, 1'b1);
    send_tick(10'd0, 1'b0, 1'b0, 1'b1);
    send_tick(10'd0, 1'b0, 1'b0, 1'b1);
    send_tick(10'd0, 1'b0, 1'b0, 1'b1);
    send_tick(10'd0, 1'b1, 1'b0, 1'b0);
    send_tick(10'd513, 1'b0, 1'b0, 1'b1);
    send_tick(10'd1023, 1'b0, 1'b1, 1'b0);
    send_tick(10'd1023, 1'b0, 1'b0, 1'b1);
    send_tick(10'd511, 1'b1, 1'b1, 1'b1);
    send_tick(10'd1023, 1'b1, 1'b1, 1'b0);
    send_tick(10'd700, 1'b0, 1'b0, 1'b1);
    drain();

    apply_settings(10'd512, 1'b1, 8'd5, 8'd5, 16'd1000, 16'd500, 16'd100);
    run_buttons(70);
    drain();

    apply_settings(10'd300, 1'b0, 8'd1, 8'd0, 16'd6, 16'd4, 16'd2);
    run_buttons(60);
    drain();

    apply_settings(10'd1023, 1'b0, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_buttons(20);
    drain();

    // Everything reads as pressed and every limit is zero.
    apply_settings(10'd1023, 1'b1, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    run_buttons(30);
    drain();

    apply_settings(10'd0, 1'b1, 8'd0, 8'd1, 16'd3, 16'd2, 16'd1);
    run_buttons(30);
    drain();

    for (int p = 0; p < 5; p++) begin
      random_settings();
      run_buttons(50);
      drain();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Checked %0d tick reports over %0d register settings: %0d presses, %0d releases.",
             tracker.checked, settings_used, tracker.presses, tracker.releases);
    $display("Saw %0d held reports and %0d auto-repeat firings.",
             tracker.held_seen, tracker.fires_seen);
    if (tracker.failures == 0 && tracker.pending_reports.size() == 0) begin
      $display("analog_button_debounce_repeat test passed");
    end else begin
      $display("analog_button_debounce_repeat test failed");
    end
    $finish;
  end

endmodule
